@@ rtl/fup_pkg.sv @@
`default_nettype none
package fup_pkg;

  localparam int DEF_FIELD_BUF_BYTES = 64;
  localparam int LEN_W = 6;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
    end else begin
      t = c - 8'h57;
    end
    hex_val = t[3:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/fup_vmem.sv @@
`default_nettype none
module fup_vmem #(
  parameter int DEPTH = fup_pkg::DEF_FIELD_BUF_BYTES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/form_urlencoded_pair_parser.sv @@
`default_nettype none
// Parses a form body, one byte per input beat, into key=value pairs. Key bytes come
// out one beat each, in the cycle after the byte is taken; value bytes are held in a
// value store and produce nothing until the pair ends on '&' or on a
// value byte marked last. The stored value is then percent-decoded by one sequencer
// that reads the store byte by byte: each plain decoded byte passes S_RD0, S_C0 and
// S_WAIT_VAL, each %hh escape S_RD0, S_C0, S_C1, S_C2 and S_WAIT_VAL, and the closing
// pair-done beat S_DONE and S_WAIT_END, each beat held until out_ready. The block takes
// no new byte while a result is pending or a value is being decoded. After an error
// beat all bytes are dropped until a byte with start_of_body set.
module form_urlencoded_pair_parser #(
  parameter int FIELD_BUF_BYTES = fup_pkg::DEF_FIELD_BUF_BYTES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [7:0]               in_body_byte,
  input  wire logic                     in_start_of_body,
  input  wire logic                     in_last_byte,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_byte,
  output logic [fup_pkg::LEN_W-1:0]     out_key_length,
  output logic [fup_pkg::LEN_W-1:0]     out_value_length,
  output logic                          out_run_end
);

  localparam int CW = $clog2(FIELD_BUF_BYTES);
  localparam logic [CW-1:0] MAX_CNT = CW'(FIELD_BUF_BYTES - 1);

  typedef enum logic [1:0] {PH_KEY, PH_VALUE, PH_ERROR} phase_t;
  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_C0, S_C1, S_C2, S_WAIT_VAL, S_DONE, S_WAIT_END
  } state_t;

  state_t        state_r;
  phase_t        phase_r;
  logic [CW-1:0] kc_r;
  logic [CW-1:0] vc_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] j_r;
  logic [3:0]    h1_r;
  logic          h1ok_r;

  logic                      out_valid_r;
  logic [1:0]                out_kind_r;
  logic [7:0]                out_byte_r;
  logic [fup_pkg::LEN_W-1:0] out_klen_r;
  logic [fup_pkg::LEN_W-1:0] out_vlen_r;
  logic                      out_run_end_r;

  logic          in_fire;
  phase_t        eff_phase;
  logic [CW-1:0] eff_kc;
  logic [CW-1:0] eff_vc;
  logic          mem_we;
  logic [CW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          esc_fits;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign eff_phase = in_start_of_body ? PH_KEY : phase_r;
  assign eff_kc    = in_start_of_body ? '0 : kc_r;
  assign eff_vc    = in_start_of_body ? '0 : vc_r;
  assign mem_we    = in_fire && (eff_phase == PH_VALUE) &&
                     (in_body_byte != fup_pkg::CH_AMP) &&
                     (in_body_byte != fup_pkg::CH_EQUAL) && (eff_vc < MAX_CNT);
  assign esc_fits  = ((CW + 1)'(i_r) + (CW + 1)'(2)) < (CW + 1)'(vc_r);

  always_comb begin
    case (state_r)
      S_C0:    rd_addr = i_r + CW'(1);
      S_C1:    rd_addr = i_r + CW'(2);
      default: rd_addr = i_r;
    endcase
  end

  fup_vmem #(
    .DEPTH (FIELD_BUF_BYTES),
    .AW    (CW)
  ) u_vmem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (eff_vc),
    .wr_data (in_body_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_KEY;
      kc_r        <= '0;
      vc_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kc_r          <= eff_kc;
            vc_r          <= eff_vc;
            phase_r       <= eff_phase;
            i_r           <= '0;
            j_r           <= '0;
            out_byte_r    <= '0;
            out_klen_r    <= '0;
            out_vlen_r    <= '0;
            out_run_end_r <= 1'b1;
            out_kind_r    <= fup_pkg::KIND_ERROR;
            case (eff_phase)
              PH_KEY: begin
                if (in_body_byte == fup_pkg::CH_EQUAL) begin
                  phase_r <= PH_VALUE;
                end else if (in_body_byte != fup_pkg::CH_AMP && eff_kc < MAX_CNT) begin
                  kc_r        <= eff_kc + CW'(1);
                  out_kind_r  <= fup_pkg::KIND_KEY;
                  out_byte_r  <= in_body_byte;
                  out_valid_r <= 1'b1;
                  state_r     <= S_WAIT_END;
                end else begin
                  phase_r     <= PH_ERROR;
                  out_valid_r <= 1'b1;
                  state_r     <= S_WAIT_END;
                end
              end
              PH_VALUE: begin
                if (in_body_byte == fup_pkg::CH_AMP) begin
                  state_r <= (eff_vc == '0) ? S_DONE : S_RD0;
                end else if (in_body_byte != fup_pkg::CH_EQUAL && eff_vc < MAX_CNT) begin
                  vc_r <= eff_vc + CW'(1);
                  if (in_last_byte) begin
                    state_r <= S_RD0;
                  end
                end else begin
                  phase_r     <= PH_ERROR;
                  out_valid_r <= 1'b1;
                  state_r     <= S_WAIT_END;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD0: begin
          state_r <= S_C0;
        end
        S_C0: begin
          if (rd_data == fup_pkg::CH_PERCENT && esc_fits) begin
            state_r <= S_C1;
          end else begin
            out_kind_r    <= fup_pkg::KIND_VALUE;
            out_byte_r    <= (rd_data == fup_pkg::CH_PLUS) ? fup_pkg::CH_SPACE : rd_data;
            out_klen_r    <= '0;
            out_vlen_r    <= '0;
            out_run_end_r <= 1'b0;
            out_valid_r   <= 1'b1;
            i_r           <= i_r + CW'(1);
            j_r           <= j_r + CW'(1);
            state_r       <= S_WAIT_VAL;
          end
        end
        S_C1: begin
          h1_r    <= fup_pkg::hex_val(rd_data);
          h1ok_r  <= fup_pkg::is_hex(rd_data);
          state_r <= S_C2;
        end
        S_C2: begin
          out_kind_r    <= fup_pkg::KIND_VALUE;
          out_klen_r    <= '0;
          out_vlen_r    <= '0;
          out_run_end_r <= 1'b0;
          out_valid_r   <= 1'b1;
          j_r           <= j_r + CW'(1);
          if (h1ok_r && fup_pkg::is_hex(rd_data)) begin
            out_byte_r <= {h1_r, fup_pkg::hex_val(rd_data)};
            i_r        <= i_r + CW'(3);
          end else begin
            out_byte_r <= fup_pkg::CH_PERCENT;
            i_r        <= i_r + CW'(1);
          end
          state_r <= S_WAIT_VAL;
        end
        S_WAIT_VAL: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= (i_r < vc_r) ? S_RD0 : S_DONE;
          end
        end
        S_DONE: begin
          out_kind_r    <= fup_pkg::KIND_DONE;
          out_byte_r    <= '0;
          out_klen_r    <= fup_pkg::LEN_W'(kc_r);
          out_vlen_r    <= fup_pkg::LEN_W'(j_r);
          out_run_end_r <= 1'b1;
          out_valid_r   <= 1'b1;
          phase_r       <= PH_KEY;
          kc_r          <= '0;
          vc_r          <= '0;
          state_r       <= S_WAIT_END;
        end
        S_WAIT_END: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte         = out_byte_r;
  assign out_key_length   = out_klen_r;
  assign out_value_length = out_vlen_r;
  assign out_run_end      = out_run_end_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == fup_pkg::KIND_DONE || out_kind == fup_pkg::KIND_ERROR)
      |-> out_run_end && out_byte == 8'd0)
    else $error("pair done or error beat malformed");
  a_value_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == fup_pkg::KIND_VALUE |-> !out_run_end)
    else $error("value byte marked as end of run");
  a_value_then_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == fup_pkg::KIND_VALUE |=> !in_ready)
    else $error("input taken before the pair done beat");
`endif

endmodule
`default_nettype wire
